/* rtl/core/terminal_key_event_parser_core_assert.svh */
// Assertion macros for the key event parser checks.
`ifndef TERMINAL_KEY_EVENT_PARSER_CORE_ASSERT_SVH
`define TERMINAL_KEY_EVENT_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define TKEP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tkep check failed");

// Next-cycle implication.
`define TKEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tkep check failed");

`endif

/* rtl/core/tkep_pkg.sv */
package tkep_pkg;

  // parser modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_CSI  = 2'd2;
  localparam logic [1:0] MODE_UTF8 = 2'd3;

  // event kinds
  localparam logic [4:0] EV_INSERT     = 5'd0;
  localparam logic [4:0] EV_BACKSPACE  = 5'd1;
  localparam logic [4:0] EV_HOME       = 5'd2;
  localparam logic [4:0] EV_LEFT       = 5'd3;
  localparam logic [4:0] EV_INTERRUPT  = 5'd4;
  localparam logic [4:0] EV_EOF        = 5'd5;
  localparam logic [4:0] EV_END        = 5'd6;
  localparam logic [4:0] EV_RIGHT      = 5'd7;
  localparam logic [4:0] EV_TAB        = 5'd8;
  localparam logic [4:0] EV_CLEAR      = 5'd9;
  localparam logic [4:0] EV_ENTER      = 5'd10;
  localparam logic [4:0] EV_SUSPEND    = 5'd11;
  localparam logic [4:0] EV_ABORT      = 5'd12;
  localparam logic [4:0] EV_UP         = 5'd13;
  localparam logic [4:0] EV_DOWN       = 5'd14;
  localparam logic [4:0] EV_WORD_LEFT  = 5'd15;
  localparam logic [4:0] EV_WORD_RIGHT = 5'd16;

  localparam logic [7:0] BYTE_ESC     = 8'h1B;
  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_DEL     = 8'h7F;
  localparam logic [7:0] BYTE_CTL_MAX = 8'h1F;
  localparam logic [7:0] BYTE_CSI_FIN = 8'h40;

  localparam logic [3:0] DFA_ACCEPT = 4'd0;
  localparam logic [3:0] DFA_REJECT = 4'd1;
  localparam logic [3:0] DFA_LAST   = 4'd8;

  localparam logic [31:0] REPLACEMENT_CHAR = 32'h00BD_BFEF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  dfa;
    logic [31:0] bytes;
    logic [2:0]  count;
    logic [2:0]  csi_len;
    logic        prefix_ok;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [4:0]  kind;
    logic [31:0] bytes;
    logic [2:0]  len;
  } result_t;

  localparam state_t STATE_RESET = '{
    mode: MODE_IDLE, dfa: DFA_ACCEPT, bytes: 32'd0, count: 3'd0,
    csi_len: 3'd0, prefix_ok: 1'b1
  };

  // next state = DFA_NEXT[state * 12 + class]
  localparam logic [3:0] DFA_NEXT [108] = '{
    4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,
    4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,
    4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,
    4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,
    4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,
    4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,
    4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1
  };

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    if (b < 8'h80)       c = 4'd0;
    else if (b < 8'h90)  c = 4'd1;
    else if (b < 8'hA0)  c = 4'd9;
    else if (b < 8'hC0)  c = 4'd7;
    else if (b < 8'hC2)  c = 4'd8;
    else if (b < 8'hE0)  c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b < 8'hF0)  c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b < 8'hF4)  c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else                 c = 4'd8;
    return c;
  endfunction

  function automatic logic [3:0] dfa_step(input logic [3:0] s, input logic [7:0] b);
    logic [3:0] sc;
    logic [6:0] idx;
    sc  = (s > DFA_LAST) ? DFA_REJECT : s;
    idx = 7'(sc) * 7'd12 + 7'(byte_class(b));
    return DFA_NEXT[idx];
  endfunction

  // keymaps: insert never comes from a keymap, so EV_INSERT marks a miss
  function automatic logic [4:0] ctrl_event(input logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      8'h7F, 8'h08: k = EV_BACKSPACE;
      8'h01:        k = EV_HOME;
      8'h02:        k = EV_LEFT;
      8'h03:        k = EV_INTERRUPT;
      8'h04:        k = EV_EOF;
      8'h05:        k = EV_END;
      8'h06:        k = EV_RIGHT;
      8'h09:        k = EV_TAB;
      8'h0C:        k = EV_CLEAR;
      8'h0D:        k = EV_ENTER;
      8'h1A:        k = EV_SUSPEND;
      8'h1C:        k = EV_ABORT;
      default:      k = EV_INSERT;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] csi_event(input logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      8'h41:   k = EV_UP;
      8'h42:   k = EV_DOWN;
      8'h43:   k = EV_RIGHT;
      8'h44:   k = EV_LEFT;
      8'h46:   k = EV_END;
      8'h48:   k = EV_HOME;
      default: k = EV_INSERT;
    endcase
    return k;
  endfunction

endpackage

/* rtl/core/tkep_decode.sv */
// One byte against the parser state: next state and optional event.
module tkep_decode (
  input  tkep_pkg::state_t  st,
  input  logic [7:0]        in_byte,
  output tkep_pkg::state_t  st_next,
  output tkep_pkg::result_t res
);

  logic [4:0]  k;
  logic [3:0]  ns;
  logic [31:0] fb;
  logic [2:0]  fc;
  logic        feed;
  logic        fresh;

  always_comb begin
    st_next = st;
    res     = '0;
    k       = tkep_pkg::EV_INSERT;
    feed    = 1'b0;
    fresh   = 1'b0;
    unique case (st.mode)
      tkep_pkg::MODE_ESC: begin
        if (in_byte == 8'h5B) begin
          st_next.mode      = tkep_pkg::MODE_CSI;
          st_next.csi_len   = 3'd0;
          st_next.prefix_ok = 1'b1;
        end else begin
          st_next.mode = tkep_pkg::MODE_IDLE;
          if (in_byte == tkep_pkg::BYTE_CR) begin
            res.valid = 1'b1;
            res.kind  = tkep_pkg::EV_INSERT;
            res.bytes = 32'(tkep_pkg::BYTE_LF);
            res.len   = 3'd1;
          end
        end
      end
      tkep_pkg::MODE_CSI: begin
        if (in_byte <= tkep_pkg::BYTE_CTL_MAX || in_byte >= tkep_pkg::BYTE_DEL) begin
          // ignored inside CSI
        end else if (in_byte < tkep_pkg::BYTE_CSI_FIN) begin
          if (st.csi_len == 3'd0 && in_byte != 8'h31) st_next.prefix_ok = 1'b0;
          if (st.csi_len == 3'd1 && in_byte != 8'h3B) st_next.prefix_ok = 1'b0;
          if (st.csi_len == 3'd2 && in_byte != 8'h35 && in_byte != 8'h33)
            st_next.prefix_ok = 1'b0;
          if (st.csi_len < 3'd4) st_next.csi_len = st.csi_len + 3'd1;
        end else begin
          st_next.mode = tkep_pkg::MODE_IDLE;
          if (st.csi_len == 3'd0) begin
            k = tkep_pkg::csi_event(in_byte);
            if (k != tkep_pkg::EV_INSERT) begin
              res.valid = 1'b1;
              res.kind  = k;
            end
          end else if (st.csi_len == 3'd3 && st.prefix_ok) begin
            if (in_byte == 8'h44) begin
              res.valid = 1'b1;
              res.kind  = tkep_pkg::EV_WORD_LEFT;
            end else if (in_byte == 8'h43) begin
              res.valid = 1'b1;
              res.kind  = tkep_pkg::EV_WORD_RIGHT;
            end
          end
        end
      end
      tkep_pkg::MODE_UTF8: begin
        feed = 1'b1;
      end
      default: begin
        if (in_byte == tkep_pkg::BYTE_ESC) begin
          st_next.mode = tkep_pkg::MODE_ESC;
        end else if (in_byte <= tkep_pkg::BYTE_CTL_MAX || in_byte == tkep_pkg::BYTE_DEL) begin
          k = tkep_pkg::ctrl_event(in_byte);
          if (k != tkep_pkg::EV_INSERT) begin
            res.valid = 1'b1;
            res.kind  = k;
          end
        end else begin
          feed  = 1'b1;
          fresh = 1'b1;
        end
      end
    endcase

    // UTF-8 path: a fresh character starts from an empty gather
    ns = tkep_pkg::dfa_step(fresh ? tkep_pkg::DFA_ACCEPT : st.dfa, in_byte);
    fb = fresh ? 32'd0 : st.bytes;
    fc = fresh ? 3'd0 : st.count;
    if (fc < 3'd4) begin
      unique case (fc[1:0])
        2'd0:    fb[7:0]   = in_byte;
        2'd1:    fb[15:8]  = in_byte;
        2'd2:    fb[23:16] = in_byte;
        default: fb[31:24] = in_byte;
      endcase
      fc = fc + 3'd1;
    end

    if (feed) begin
      st_next.bytes = fb;
      st_next.count = fc;
      if (ns == tkep_pkg::DFA_ACCEPT) begin
        st_next.mode = tkep_pkg::MODE_IDLE;
        st_next.dfa  = tkep_pkg::DFA_ACCEPT;
        res.valid    = 1'b1;
        res.kind     = tkep_pkg::EV_INSERT;
        res.bytes    = fb;
        res.len      = fc;
      end else if (ns == tkep_pkg::DFA_REJECT) begin
        st_next.mode = tkep_pkg::MODE_IDLE;
        st_next.dfa  = tkep_pkg::DFA_ACCEPT;
        res.valid    = 1'b1;
        res.kind     = tkep_pkg::EV_INSERT;
        res.bytes    = tkep_pkg::REPLACEMENT_CHAR;
        res.len      = 3'd3;
      end else begin
        st_next.mode = tkep_pkg::MODE_UTF8;
        st_next.dfa  = ns;
      end
    end
  end

endmodule

/* rtl/core/terminal_key_event_parser_core.sv */
// Flow: a byte accepted into the input register is decoded, and its event written into the output register.
// Throughput: one byte per cycle; the input register feeds the output register
//   through one pass of the decoder, and both stall only when the output is held.
// Reset (rst, synchronous, active high): empties both registers, returns the
//   parser to idle with the UTF-8 DFA in its accept state.
module terminal_key_event_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  event_kind,
  output logic [31:0] char_bytes,
  output logic [2:0]  char_len
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // parser state and decoder outputs
  tkep_pkg::state_t  st;
  tkep_pkg::state_t  st_next;
  tkep_pkg::result_t res;

  logic out_free;  // output register can take a new request this cycle
  logic s1_go;     // byte in the input register is decoded and retired

  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && out_free;
  // the input register holds only while its byte cannot retire
  assign in_stall = s1_valid && !out_free;

  tkep_decode u_decode (
    .st      (st),
    .in_byte (s1_byte),
    .st_next (st_next),
    .res     (res)
  );

  // control: valids and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= tkep_pkg::STATE_RESET;
    end else begin
      if (!in_stall) s1_valid <= in_valid;
      // a byte that makes no event retires without filling the output
      if (out_free) out_valid <= s1_go && res.valid;
      if (s1_go) st <= st_next;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_byte <= in_byte;
    if (s1_go && res.valid) begin
      event_kind <= res.kind;
      char_bytes <= res.bytes;
      char_len   <= res.len;
    end
  end

endmodule

/* rtl/core/tkep_checker.sv */
`include "terminal_key_event_parser_core_assert.svh"

module tkep_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  event_kind,
  input logic [31:0] char_bytes,
  input logic [2:0]  char_len
);

  logic        is_insert;
  logic        no_char;
  logic        len_ok;
  logic [39:0] out_word;

  assign is_insert = event_kind == tkep_pkg::EV_INSERT;
  assign no_char   = char_len == 3'd0 && char_bytes == 32'd0;
  assign len_ok    = char_len >= 3'd1 && char_len <= 3'd4;
  assign out_word  = {event_kind, char_bytes, char_len};

  `TKEP_ASSERT_NOW(a_kind_range, clk, rst, out_valid, event_kind <= tkep_pkg::EV_WORD_RIGHT)
  `TKEP_ASSERT_NOW(a_key_no_char, clk, rst, out_valid && !is_insert, no_char)
  `TKEP_ASSERT_NOW(a_insert_len, clk, rst, out_valid && is_insert, len_ok)
  `TKEP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))
  // input backs up only behind a held result
  `TKEP_ASSERT_NOW(a_in_stall, clk, rst, in_stall, out_valid && out_stall)

endmodule

bind terminal_key_event_parser_core tkep_checker u_tkep_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .event_kind (event_kind),
  .char_bytes (char_bytes),
  .char_len   (char_len)
);

/* sim/tb_terminal_key_event_parser_core.sv */
`timescale 1ns / 1ps

module tb_terminal_key_event_parser_core;

  localparam int RANDOM_ITEMS  = 800;   // random bytes that matter, filler not counted
  localparam int CALM_ITEMS    = 150;   // tail of the run with no idling at all
  localparam int FILL_ITEMS    = 40;    // bytes offered while the output is held
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 10;    // two register stages, plenty of margin
  localparam int CYCLE_LIMIT   = 200000;

  localparam logic [7:0] BYTE_CSI_OPEN = 8'h5B;  // '[' after ESC opens a CSI

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] bytes;
    logic [2:0]  len;
  } key_event_t;

  // one directed request; when typed is set the event is written out here
  typedef struct packed {
    logic [7:0] key;
    logic       typed;
    key_event_t ev;
  } key_row_t;

  localparam key_event_t REPLACEMENT_EV =
    {tkep_pkg::EV_INSERT, tkep_pkg::REPLACEMENT_CHAR, 3'd3};

  // Directed part: extremes of the byte range, keymap hits and misses, the
  // largest code point, a rejected second byte, ESC CR, a short CSI and a
  // word move with an ignored control byte inside the CSI.
  localparam key_row_t DIRECTED [25] = '{
    {8'h20, 1'b1, tkep_pkg::EV_INSERT, 32'h0000_0020, 3'd1},   // lowest printable
    {8'h7E, 1'b1, tkep_pkg::EV_INSERT, 32'h0000_007E, 3'd1},   // highest printable
    {8'h00, 1'b0, 40'd0},                            // unmapped control, dropped
    {8'h7F, 1'b1, tkep_pkg::EV_BACKSPACE, 32'd0, 3'd0},
    {8'h0D, 1'b1, tkep_pkg::EV_ENTER, 32'd0, 3'd0},
    {8'hFF, 1'b1, REPLACEMENT_EV},                   // never a valid lead
    {8'h80, 1'b1, REPLACEMENT_EV},                   // stray continuation
    {8'hF4, 1'b0, 40'd0},                            // U+10FFFF, four bytes
    {8'h8F, 1'b0, 40'd0},
    {8'hBF, 1'b0, 40'd0},
    {8'hBF, 1'b0, 40'd0},
    {8'hE0, 1'b0, 40'd0},                            // overlong: E0 needs A0..BF
    {8'h9F, 1'b0, 40'd0},
    {8'h1B, 1'b0, 40'd0},                            // ESC CR gives a newline
    {8'h0D, 1'b1, tkep_pkg::EV_INSERT, 24'd0, tkep_pkg::BYTE_LF, 3'd1},
    {8'h1B, 1'b0, 40'd0},                            // ESC [ A
    {8'h5B, 1'b0, 40'd0},
    {8'h41, 1'b1, tkep_pkg::EV_UP, 32'd0, 3'd0},
    {8'h1B, 1'b0, 40'd0},                            // ESC [ 1 ; 3 ^G C
    {8'h5B, 1'b0, 40'd0},
    {8'h31, 1'b0, 40'd0},
    {8'h3B, 1'b0, 40'd0},
    {8'h33, 1'b0, 40'd0},
    {8'h07, 1'b0, 40'd0},
    {8'h43, 1'b0, 40'd0}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [4:0]  event_kind;
  logic [31:0] char_bytes;
  logic [2:0]  char_len;

  terminal_key_event_parser_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .char_bytes (char_bytes),
    .char_len   (char_len)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Events still owed by the parser, oldest first.
  key_event_t pending_events [$];

  int          failures       = 0;
  int          events_checked = 0;
  int          bytes_sent     = 0;
  int          cycle_count    = 0;
  logic [31:0] kinds_seen     = '0;

  // Idling controls, written by the sender, read by the receiver too.
  bit sender_gaps  = 1'b1;
  bit rx_stalls    = 1'b1;
  bit hold_request = 1'b0;

  // Parser shadow state.
  logic [1:0]  key_mode    = tkep_pkg::MODE_IDLE;
  int          utf_left    = 0;       // continuation bytes still owed
  logic [7:0]  utf_lo      = 8'h80;   // legal range of the next continuation
  logic [7:0]  utf_hi      = 8'hBF;
  logic [31:0] utf_bytes   = '0;
  logic [2:0]  utf_count   = '0;
  logic [2:0]  csi_count   = '0;      // parameter bytes, saturates at 4
  logic        csi_word_ok = 1'b1;    // still on track for "1;5" or "1;3"

  // Advance the shadow parser by one byte; hit says whether an event comes out.
  task automatic decode_key_byte(input logic [7:0] b, output bit hit, output key_event_t ev);
    logic [4:0] k;
    hit = 1'b0;
    ev  = '0;
    k   = tkep_pkg::EV_INSERT;  // insert never comes from a keymap, so it means no key
    case (key_mode)
      tkep_pkg::MODE_ESC: begin
        if (b == BYTE_CSI_OPEN) begin
          key_mode    = tkep_pkg::MODE_CSI;
          csi_count   = 3'd0;
          csi_word_ok = 1'b1;
        end else begin
          // anything else after ESC is swallowed, CR alone becomes a newline
          key_mode = tkep_pkg::MODE_IDLE;
          if (b == tkep_pkg::BYTE_CR) begin
            hit = 1'b1;
            ev  = {tkep_pkg::EV_INSERT, 24'd0, tkep_pkg::BYTE_LF, 3'd1};
          end
        end
      end
      tkep_pkg::MODE_CSI: begin
        // controls and high bytes inside a CSI are skipped
        if (b > tkep_pkg::BYTE_CTL_MAX && b < tkep_pkg::BYTE_DEL) begin
          if (b < tkep_pkg::BYTE_CSI_FIN) begin
            if (csi_count == 3'd0 && b != "1") csi_word_ok = 1'b0;
            if (csi_count == 3'd1 && b != ";") csi_word_ok = 1'b0;
            if (csi_count == 3'd2 && b != "5" && b != "3") csi_word_ok = 1'b0;
            if (csi_count < 3'd4) csi_count = csi_count + 3'd1;
          end else begin
            key_mode = tkep_pkg::MODE_IDLE;
            if (csi_count == 3'd0) begin
              case (b)
                "A":     k = tkep_pkg::EV_UP;
                "B":     k = tkep_pkg::EV_DOWN;
                "C":     k = tkep_pkg::EV_RIGHT;
                "D":     k = tkep_pkg::EV_LEFT;
                "F":     k = tkep_pkg::EV_END;
                "H":     k = tkep_pkg::EV_HOME;
                default: k = tkep_pkg::EV_INSERT;
              endcase
            end else if (csi_count == 3'd3 && csi_word_ok) begin
              if (b == "D") k = tkep_pkg::EV_WORD_LEFT;
              else if (b == "C") k = tkep_pkg::EV_WORD_RIGHT;
            end
          end
        end
      end
      tkep_pkg::MODE_UTF8: begin
        // every byte counts as a continuation here, even ESC and controls
        utf_bytes = utf_bytes | ({24'd0, b} << (8 * utf_count));
        utf_count = utf_count + 3'd1;
        hit       = 1'b1;
        key_mode  = tkep_pkg::MODE_IDLE;
        if (b < utf_lo || b > utf_hi) begin
          ev = REPLACEMENT_EV;
        end else if (utf_left == 1) begin
          ev = {tkep_pkg::EV_INSERT, utf_bytes, utf_count};
        end else begin
          hit      = 1'b0;
          key_mode = tkep_pkg::MODE_UTF8;
          utf_left = utf_left - 1;
          utf_lo   = 8'h80;
          utf_hi   = 8'hBF;
        end
      end
      default: begin
        if (b == tkep_pkg::BYTE_ESC) begin
          key_mode = tkep_pkg::MODE_ESC;
        end else if (b <= tkep_pkg::BYTE_CTL_MAX || b == tkep_pkg::BYTE_DEL) begin
          case (b)
            8'h7F, 8'h08: k = tkep_pkg::EV_BACKSPACE;
            8'h01:        k = tkep_pkg::EV_HOME;
            8'h02:        k = tkep_pkg::EV_LEFT;
            8'h03:        k = tkep_pkg::EV_INTERRUPT;
            8'h04:        k = tkep_pkg::EV_EOF;
            8'h05:        k = tkep_pkg::EV_END;
            8'h06:        k = tkep_pkg::EV_RIGHT;
            8'h09:        k = tkep_pkg::EV_TAB;
            8'h0C:        k = tkep_pkg::EV_CLEAR;
            8'h0D:        k = tkep_pkg::EV_ENTER;
            8'h1A:        k = tkep_pkg::EV_SUSPEND;
            8'h1C:        k = tkep_pkg::EV_ABORT;
            default:      k = tkep_pkg::EV_INSERT;
          endcase
        end else begin
          // lead byte: work out how many continuations follow and their range
          utf_bytes = {24'd0, b};
          utf_count = 3'd1;
          utf_lo    = 8'h80;
          utf_hi    = 8'hBF;
          utf_left  = 0;
          if (b >= 8'hC2 && b <= 8'hDF) begin
            utf_left = 1;
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            utf_left = 2;
            if (b == 8'hE0) utf_lo = 8'hA0;   // no overlongs
            if (b == 8'hED) utf_hi = 8'h9F;   // no surrogates
          end else if (b >= 8'hF0 && b <= 8'hF4) begin
            utf_left = 3;
            if (b == 8'hF0) utf_lo = 8'h90;
            if (b == 8'hF4) utf_hi = 8'h8F;   // stop at U+10FFFF
          end
          if (b < 8'h80) begin
            hit = 1'b1;
            ev  = {tkep_pkg::EV_INSERT, utf_bytes, 3'd1};
          end else if (utf_left == 0) begin
            hit = 1'b1;
            ev  = REPLACEMENT_EV;
          end else begin
            key_mode = tkep_pkg::MODE_UTF8;
          end
        end
      end
    endcase
    if (k != tkep_pkg::EV_INSERT) begin
      hit = 1'b1;
      ev  = {k, 32'd0, 3'd0};
    end
  endtask

  // Offer one byte, hold it until accepted, then log what it should produce.
  // Valid and stall are sampled just after the edge, so they hold the values
  // that the block saw at that edge.
  task automatic send_key_byte(input logic [7:0] b, input bit typed, input key_event_t typed_ev);
    bit         hit;
    key_event_t ev;
    if (sender_gaps && $urandom_range(7, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    decode_key_byte(b, hit, ev);
    if (typed) begin
      hit = 1'b1;
      ev  = typed_ev;
    end
    if (hit) pending_events.push_back(ev);
    bytes_sent++;
  endtask

  // Receiver: checks each accepted event and drives out_stall for the next
  // cycle. A hold request from the sender gives one long stall counted here.
  int hold_left  = 0;
  int stall_left = 0;

  always @(posedge clk) begin : receiver
    key_event_t want;
    if (!rst && out_valid && !out_stall) begin
      kinds_seen[event_kind] = 1'b1;
      if (pending_events.size() == 0) begin
        $error("unexpected event: kind %0d bytes %h len %0d", event_kind, char_bytes, char_len);
        failures++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind) begin
          $error("event_kind mismatch: expected %0d, actual %0d", want.kind, event_kind);
          failures++;
        end
        if (char_bytes !== want.bytes) begin
          $error("char_bytes mismatch: expected %h, actual %h", want.bytes, char_bytes);
          failures++;
        end
        if (char_len !== want.len) begin
          $error("char_len mismatch: expected %0d, actual %0d", want.len, char_len);
          failures++;
        end
        events_checked++;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rx_stalls && $urandom_range(5, 0) == 0) begin
      stall_left = $urandom_range(15, 0);  // start a stall burst of random length
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d events still pending",
             cycle_count, pending_events.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] token [$];
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    int         random_items;
    int         filler;
    int         pick;
    int         n;
    int         pos;
    int         sel;

    random_items = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_key_byte(DIRECTED[i].key, DIRECTED[i].typed, DIRECTED[i].ev);

    // Sender pause: let every owed event come out before going on.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);

    // Back-pressure: output held for a long stretch while printable bytes
    // keep coming, so both registers fill and in_stall rises.
    sender_gaps  = 1'b0;
    hold_request = 1'b1;
    repeat (FILL_ITEMS) send_key_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b0, '0);

    // Random part: mostly well-formed keys and characters with random
    // content, the rest raw bytes and broken sequences.
    while (random_items < RANDOM_ITEMS) begin
      // idling on most of the time, quiet windows, none at the tail
      sender_gaps = (random_items % 200 < 150) && (random_items < RANDOM_ITEMS - CALM_ITEMS);
      rx_stalls   = ((random_items + 100) % 200 < 150) &&
                    (random_items < RANDOM_ITEMS - CALM_ITEMS);
      token.delete();
      filler = 0;
      pick   = $urandom_range(99, 0);
      if (pick < 15) begin
        repeat ($urandom_range(4, 1)) token.push_back(8'($urandom_range(8'h7E, 8'h20)));
      end else if (pick < 25) begin
        // any control byte, DEL included; ESC here just opens an escape
        sel = $urandom_range(32, 0);
        token.push_back(sel == 32 ? tkep_pkg::BYTE_DEL : 8'(sel));
      end else if (pick < 45) begin
        // UTF-8 of 2..4 bytes; the upper share is cut short and ends in a random byte
        n = $urandom_range(4, 2);
        case (n)
          2:       lead = 8'($urandom_range(8'hDF, 8'hC2));
          3:       lead = 8'($urandom_range(8'hEF, 8'hE0));
          default: lead = 8'($urandom_range(8'hF4, 8'hF0));
        endcase
        lo = 8'h80;
        hi = 8'hBF;
        if (lead == 8'hE0) lo = 8'hA0;
        if (lead == 8'hED) hi = 8'h9F;
        if (lead == 8'hF0) lo = 8'h90;
        if (lead == 8'hF4) hi = 8'h8F;
        token.push_back(lead);
        token.push_back(8'($urandom_range(hi, lo)));
        repeat (n - 2) token.push_back(8'($urandom_range(8'hBF, 8'h80)));
        if (pick >= 37) begin
          pos = $urandom_range(n - 1, 1);
          while (token.size() > pos) void'(token.pop_back());
          sel = $urandom_range(2, 0);
          if (sel == 0)      token.push_back(8'($urandom_range(8'h7F, 8'h00)));
          else if (sel == 1) token.push_back(8'($urandom_range(8'hFF, 8'hC0)));
          else               token.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end
      end else if (pick < 51) begin
        token.push_back(8'($urandom_range(255, 0)));
      end else if (pick < 56) begin
        token.push_back(tkep_pkg::BYTE_ESC);
        token.push_back(tkep_pkg::BYTE_CR);
      end else if (pick < 60) begin
        token.push_back(tkep_pkg::BYTE_ESC);
        token.push_back(8'($urandom_range(255, 0)));
      end else begin
        token.push_back(tkep_pkg::BYTE_ESC);
        token.push_back(BYTE_CSI_OPEN);
        if (pick < 74) begin
          // one-byte CSI: mapped keys mostly, any final now and then
          sel = $urandom_range(7, 0);
          case (sel)
            0:       token.push_back("A");
            1:       token.push_back("B");
            2:       token.push_back("C");
            3:       token.push_back("D");
            4:       token.push_back("F");
            5:       token.push_back("H");
            default: token.push_back(8'($urandom_range(8'h7E, 8'h40)));
          endcase
        end else if (pick < 88) begin
          // word move, sometimes with a bent prefix or final
          token.push_back("1");
          token.push_back(";");
          token.push_back($urandom_range(1, 0) ? "5" : "3");
          if ($urandom_range(4, 0) == 0)
            token[$urandom_range(4, 2)] = 8'($urandom_range(8'h3F, 8'h20));
          if ($urandom_range(5, 0) == 0)
            token.push_back(8'($urandom_range(8'h7E, 8'h40)));
          else
            token.push_back($urandom_range(1, 0) ? "C" : "D");
        end else begin
          // parameter run of 1 to 6 bytes, can saturate the length count
          repeat ($urandom_range(6, 1)) token.push_back(8'($urandom_range(8'h3F, 8'h20)));
          token.push_back(8'($urandom_range(8'h7E, 8'h40)));
        end
        // a skipped byte somewhere after the opener
        if ($urandom_range(2, 0) == 0) begin
          filler = 1;
          token.insert($urandom_range(token.size() - 1, 2),
                       $urandom_range(1, 0) ? 8'($urandom_range(31, 0))
                                            : 8'($urandom_range(255, 127)));
        end
      end
      foreach (token[i]) send_key_byte(token[i], 1'b0, '0);
      random_items += token.size() - filler;
    end

    // Drain, then give the pipeline time to show any stray event.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d bytes (directed, held-output fill, random keys/UTF-8/CSI/noise),",
             bytes_sent);
    $display("     %0d events checked, %0d of 17 event kinds seen, %0d failures.",
             events_checked, $countones(kinds_seen), failures);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/tkep_pkg.sv
rtl/core/tkep_decode.sv
rtl/core/terminal_key_event_parser_core.sv
rtl/core/tkep_checker.sv
sim/tb_terminal_key_event_parser_core.sv
